### hdl/tms_pkg.sv
// ----------------------------------------------------------------------------
// tms_pkg
// shared types and constants of the turing machine stepper
// ----------------------------------------------------------------------------
package tms_pkg;

	localparam int unsigned STATE_W = 3;
	localparam int unsigned LIMIT_W = 32;
	localparam int unsigned TABLE_W = 40;
	localparam int unsigned RULE_W  = 5;
	localparam int unsigned CFG_W   = TABLE_W;
	localparam int unsigned ONES_W  = 17;
	localparam int unsigned POS_W   = 16;

	// configuration register index
	typedef enum logic [1:0] {
		REG_START_STATE = 2'd0,
		REG_STEP_LIMIT  = 2'd1,
		REG_RULE_LOW    = 2'd2,
		REG_RULE_HIGH   = 2'd3
	} reg_index_t;

	// one rule, packed as in the table: next state, move right, write bit
	typedef struct packed {
		logic [STATE_W-1:0] next_state;
		logic               move_right;
		logic               write_bit;
	} rule_t;

	// configuration registers as seen by the core
	typedef struct packed {
		logic [STATE_W-1:0] start_state;
		logic [LIMIT_W-1:0] step_limit;
		logic [TABLE_W-1:0] rule_low;
		logic [TABLE_W-1:0] rule_high;
	} cfg_t;

	// rule lookup for a state and the bit read under the head
	function automatic rule_t get_rule(
		input logic [TABLE_W-1:0] rule_low,
		input logic [TABLE_W-1:0] rule_high,
		input logic [STATE_W-1:0] state,
		input logic               rd_bit
	);
		logic [TABLE_W-1:0] tbl;
		logic [2:0]         slot;
		tbl  = state[2] ? rule_high : rule_low;
		slot = {state[1:0], rd_bit};
		return rule_t'(tbl[slot * RULE_W +: RULE_W]);
	endfunction

endpackage

### hdl/tms_ram.sv
// ----------------------------------------------------------------------------
// tms_ram
// generic single-port ram, registered read, read data holds between reads
// ----------------------------------------------------------------------------
module tms_ram #(
	parameter int unsigned WIDTH = 1,
	parameter int unsigned DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/tms_cfg.sv
// ----------------------------------------------------------------------------
// tms_cfg
// configuration register file of the turing machine stepper
// ----------------------------------------------------------------------------
module tms_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [1:0]                 cfg_index,
	input  logic [tms_pkg::CFG_W-1:0]  cfg_data,
	output tms_pkg::cfg_t              cfg
);

	tms_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wen) begin
			unique case (tms_pkg::reg_index_t'(cfg_index))
				tms_pkg::REG_START_STATE: cfg_q.start_state <= cfg_data[tms_pkg::STATE_W-1:0];
				tms_pkg::REG_STEP_LIMIT:  cfg_q.step_limit  <= cfg_data[tms_pkg::LIMIT_W-1:0];
				tms_pkg::REG_RULE_LOW:    cfg_q.rule_low    <= cfg_data[tms_pkg::TABLE_W-1:0];
				tms_pkg::REG_RULE_HIGH:   cfg_q.rule_high   <= cfg_data[tms_pkg::TABLE_W-1:0];
				default:                  cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/turing_machine_stepper.sv
// ----------------------------------------------------------------------------
// turing_machine_stepper
// binary-tape turing machine, one step or one restart per input word
// ----------------------------------------------------------------------------
// flow: an accepted word reads the tape cell under the head; the execute state
//   writes the cell back on a step and raises the result word once no pending
//   result is stalled; no new word is accepted before then (single-port tape ram)
// reset: registers and machine go to reset values at once; the tape needs no
//   clearing pass, cells outside the span written since restart read as zero
// ----------------------------------------------------------------------------
module turing_machine_stepper #(
	parameter int unsigned TAPE_CELLS  = 65536,
	parameter int unsigned STATE_COUNT = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,

	// configuration write port
	input  logic                         cfg_wen,
	input  logic [1:0]                   cfg_index,
	input  logic [tms_pkg::CFG_W-1:0]    cfg_data,

	// input word
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         restart,

	// result word
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [tms_pkg::ONES_W-1:0]   ones_count,
	output logic [tms_pkg::STATE_W-1:0]  current_state,
	output logic [tms_pkg::POS_W-1:0]    head_position,
	output logic                         finished,
	output logic                         off_tape
);

	localparam int unsigned HEAD_W     = $clog2(TAPE_CELLS);
	localparam int unsigned CNT_W      = $clog2(TAPE_CELLS + 1);
	localparam int unsigned ONES_MAX   = (1 << tms_pkg::ONES_W) - 1;
	localparam logic [HEAD_W-1:0] HEAD_MID  = HEAD_W'(TAPE_CELLS / 2);
	localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(TAPE_CELLS - 1);
	localparam logic [tms_pkg::STATE_W-1:0] STATE_TOP = tms_pkg::STATE_W'(STATE_COUNT - 1);

	// control: accept word and read tape, then execute and write back
	typedef enum logic {
		S_IDLE,
		S_EXEC
	} fsm_t;

	fsm_t                         state_q;
	logic                         restart_s1;

	// machine state
	logic [HEAD_W-1:0]            head_q;
	logic [tms_pkg::STATE_W-1:0]  mstate_q;
	logic [tms_pkg::LIMIT_W-1:0]  steps_q;
	logic [CNT_W-1:0]             ones_q;
	logic                         edge_q;
	logic                         out_valid_q;

	// span of tape written since restart, everything outside reads as zero
	logic                         span_valid_q;
	logic [HEAD_W-1:0]            span_lo_q;
	logic [HEAD_W-1:0]            span_hi_q;

	tms_pkg::cfg_t                cfg;
	tms_pkg::rule_t               rule;

	logic                         ram_en;
	logic                         ram_we;
	logic                         ram_rdata;
	logic                         rd_bit;
	logic                         in_span;
	logic                         slot_free;
	logic                         complete;
	logic                         do_step;
	logic [tms_pkg::STATE_W-1:0]  nx_state;
	logic [tms_pkg::STATE_W-1:0]  start_clamped;

	tms_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// tape store, one bit per cell
	tms_ram #(
		.WIDTH (1),
		.DEPTH (TAPE_CELLS)
	) u_tape (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (head_q),
		.wdata (rule.write_bit),
		.rdata (ram_rdata)
	);

	// accept only when idle; a pending result does not block acceptance
	assign in_stall  = (state_q != S_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign complete  = (state_q == S_EXEC) && slot_free;
	assign do_step   = complete && !restart_s1 && (steps_q != '0);

	// read on accept, write back the new cell value on a step
	assign ram_en = (in_valid && state_q == S_IDLE) || do_step;
	assign ram_we = do_step;

	// head address is unchanged between read and execute
	assign in_span = span_valid_q && (head_q >= span_lo_q) && (head_q <= span_hi_q);
	assign rd_bit  = in_span & ram_rdata;
	assign rule    = tms_pkg::get_rule(cfg.rule_low, cfg.rule_high, mstate_q, rd_bit);

	// states at or above the state count saturate to the top state
	always_comb begin
		nx_state      = rule.next_state;
		start_clamped = cfg.start_state;
		if ({1'b0, rule.next_state} >= 4'(STATE_COUNT)) begin
			nx_state = STATE_TOP;
		end
		if ({1'b0, cfg.start_state} >= 4'(STATE_COUNT)) begin
			start_clamped = STATE_TOP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			restart_s1   <= 1'b0;
			head_q       <= HEAD_MID;
			mstate_q     <= '0;
			steps_q      <= '0;
			ones_q       <= '0;
			edge_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			span_valid_q <= 1'b0;
			span_lo_q    <= HEAD_MID;
			span_hi_q    <= HEAD_MID;
		end else begin
			// result word leaves
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						restart_s1 <= restart;
						state_q    <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (complete) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b1;
						if (restart_s1) begin
							head_q       <= HEAD_MID;
							mstate_q     <= start_clamped;
							steps_q      <= cfg.step_limit;
							ones_q       <= '0;
							edge_q       <= 1'b0;
							span_valid_q <= 1'b0;
						end else if (do_step) begin
							// keep ones count in step with the cell change
							if (rd_bit != rule.write_bit) begin
								if (rule.write_bit) begin
									ones_q <= ones_q + 1'b1;
								end else begin
									ones_q <= ones_q - 1'b1;
								end
							end
							// grow the written span
							if (!span_valid_q) begin
								span_valid_q <= 1'b1;
								span_lo_q    <= head_q;
								span_hi_q    <= head_q;
							end else begin
								if (head_q < span_lo_q) begin
									span_lo_q <= head_q;
								end
								if (head_q > span_hi_q) begin
									span_hi_q <= head_q;
								end
							end
							// move, head stays at the tape edge
							if (rule.move_right) begin
								if (head_q == HEAD_LAST) begin
									edge_q <= 1'b1;
								end else begin
									head_q <= head_q + 1'b1;
								end
							end else begin
								if (head_q == '0) begin
									edge_q <= 1'b1;
								end else begin
									head_q <= head_q - 1'b1;
								end
							end
							mstate_q <= nx_state;
							steps_q  <= steps_q - 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result fields come straight from machine state, which holds while
	// a result word waits
	assign out_valid     = out_valid_q;
	assign ones_count    = (32'(ones_q) > ONES_MAX) ? tms_pkg::ONES_W'(ONES_MAX)
	                                                : tms_pkg::ONES_W'(ones_q);
	assign current_state = mstate_q;
	assign head_position = tms_pkg::POS_W'(head_q);
	assign finished      = (steps_q == '0);
	assign off_tape      = edge_q;

endmodule
